[rtl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern search block.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned SIG_BYTES  = 16;
    localparam int unsigned PLEN_W     = 5;
    localparam int unsigned CARE_W     = 16;
    localparam int unsigned ADDR_W     = 64;

    typedef enum logic [2:0] {
        REG_PAT_LO = 3'd0,
        REG_PAT_HI = 3'd1,
        REG_CARE   = 3'd2,
        REG_PLEN   = 3'd3,
        REG_BASE   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [8*SIG_BYTES-1:0] pattern;
        logic [CARE_W-1:0]      care;
        logic [PLEN_W-1:0]      plen;
        logic [ADDR_W-1:0]      base;
    } t_cfg;

endpackage

[rtl/mbps_ifs.sv]
// ----------------------------------------------------------------------------
// mbps interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbps_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface mbps_result_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [63:0] match_address;

    modport source (output valid, output match_found, output match_address, input ready);
    modport sink   (input valid, input match_found, input match_address, output ready);
endinterface

[rtl/mbps_regs.sv]
// ----------------------------------------------------------------------------
// mbps_regs
// APB configuration registers: signature, care mask, length, region base.
// ----------------------------------------------------------------------------
module mbps_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mbps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mbps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output mbps_pkg::t_cfg                      o_cfg
);

    logic [63:0]                     r_pat_lo;
    logic [63:0]                     r_pat_hi;
    logic [mbps_pkg::CARE_W-1:0]     r_care;
    logic [mbps_pkg::PLEN_W-1:0]     r_plen;
    logic [mbps_pkg::ADDR_W-1:0]     r_base;
    mbps_pkg::t_reg_idx              w_idx;
    logic                            w_wr;

    assign w_idx  = mbps_pkg::t_reg_idx'(paddr[5:3]);
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '0;
            r_plen   <= mbps_pkg::PLEN_W'(1);
            r_base   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                mbps_pkg::REG_PAT_LO: r_pat_lo <= pwdata;
                mbps_pkg::REG_PAT_HI: r_pat_hi <= pwdata;
                mbps_pkg::REG_CARE:   r_care   <= pwdata[mbps_pkg::CARE_W-1:0];
                mbps_pkg::REG_PLEN:   r_plen   <= pwdata[mbps_pkg::PLEN_W-1:0];
                mbps_pkg::REG_BASE:   r_base   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mbps_pkg::REG_PAT_LO: prdata = r_pat_lo;
            mbps_pkg::REG_PAT_HI: prdata = r_pat_hi;
            mbps_pkg::REG_CARE:   prdata = 64'(r_care);
            mbps_pkg::REG_PLEN:   prdata = 64'(r_plen);
            mbps_pkg::REG_BASE:   prdata = r_base;
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.pattern = {r_pat_hi, r_pat_lo};
    assign o_cfg.care    = r_care;
    assign o_cfg.plen    = r_plen;
    assign o_cfg.base    = r_base;

endmodule

[rtl/mbps_front.sv]
// ----------------------------------------------------------------------------
// mbps_front
// Takes bytes, shifts the window, runs the masked compare and tracks the
// first match offset; hands one result per region to the queue.
// ----------------------------------------------------------------------------
module mbps_front #(
    parameter int unsigned MAX_PATTERN = 16,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    mbps_byte_if.sink               i_in,
    input  mbps_pkg::t_cfg          i_cfg,
    input  logic                    i_q_full,
    output logic                    o_push,
    output logic                    o_found,
    output logic [COUNT_WIDTH-1:0]  o_offset
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

    logic [7:0]             r_window [MAX_PATTERN];
    logic [7:0]             w_win    [MAX_PATTERN];
    logic [7:0]             w_sig    [MAX_PATTERN];
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_found;
    logic                   n_found;
    logic [COUNT_WIDTH-1:0] r_offset;
    logic [COUNT_WIDTH-1:0] n_offset;
    logic [LEN_W-1:0]       w_len;
    logic [LEN_W-1:0]       w_len_m1;
    logic                   w_miss;
    logic                   w_sat;
    logic                   w_hit;
    logic                   w_take;

    assign i_in.ready = !i_q_full;
    assign w_take     = i_in.valid && i_in.ready;

    assign w_len    = (i_cfg.plen > mbps_pkg::PLEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                                    : i_cfg.plen[LEN_W-1:0];
    assign w_len_m1 = w_len - LEN_W'(1);

    always_comb begin
        w_win[0] = i_in.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            w_win[k] = r_window[k-1];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_sig[j] = i_cfg.pattern[8*j +: 8];
        end
        w_miss = 1'b0;
        // byte j of the signature lines up with window entry len-1-j
        for (int j = 0; j < MAX_PATTERN; j++) begin
            for (int k = 0; k < MAX_PATTERN - j; k++) begin
                if (i_cfg.care[j] && (w_len == LEN_W'(j + k + 1)) && (w_win[k] != w_sig[j])) begin
                    w_miss = 1'b1;
                end
            end
        end
    end

    assign w_sat = &r_count;
    assign w_hit = (w_len == '0) ||
                   ((r_count >= COUNT_WIDTH'(w_len_m1)) && !w_miss);

    always_comb begin
        n_found  = r_found;
        n_offset = r_offset;
        n_count  = r_count;
        if (!w_sat) begin
            n_count = r_count + COUNT_WIDTH'(1);
            if (!r_found && w_hit) begin
                n_found  = 1'b1;
                n_offset = (w_len == '0) ? '0 : r_count - COUNT_WIDTH'(w_len_m1);
            end
        end
    end

    assign o_push   = w_take && i_in.region_end;
    assign o_found  = n_found;
    assign o_offset = n_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_found  <= 1'b0;
            r_offset <= '0;
        end else if (w_take) begin
            if (i_in.region_end) begin
                r_count  <= '0;
                r_found  <= 1'b0;
                r_offset <= '0;
            end else begin
                r_count  <= n_count;
                r_found  <= n_found;
                r_offset <= n_offset;
            end
        end
    end

    // entries beyond the byte count are never compared, so no reset here
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= w_win[k];
            end
        end
    end

endmodule

[rtl/mbps_queue.sv]
// ----------------------------------------------------------------------------
// mbps_queue
// Two-entry result queue between the scan front and the output stage.
// ----------------------------------------------------------------------------
module mbps_queue #(
    parameter int unsigned WIDTH = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_fill;
    logic             w_pop;

    assign o_valid = (r_fill != 2'd0);
    assign o_full  = (r_fill == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/mbps_back.sv]
// ----------------------------------------------------------------------------
// mbps_back
// Output stage: forms the absolute match address and holds the result item.
// ----------------------------------------------------------------------------
module mbps_back #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mbps_pkg::t_cfg          i_cfg,
    input  logic                    i_q_valid,
    input  logic                    i_q_found,
    input  logic [COUNT_WIDTH-1:0]  i_q_offset,
    output logic                    o_pop,
    mbps_result_if.source           o_out
);

    logic                       r_valid;
    logic                       r_found;
    logic [mbps_pkg::ADDR_W-1:0] r_addr;

    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_found <= i_q_found;
            r_addr  <= i_q_found ? i_cfg.base + mbps_pkg::ADDR_W'(i_q_offset) : '0;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.match_found   = r_found;
    assign o_out.match_address = r_addr;

endmodule

[rtl/masked_byte_pattern_search.sv]
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Wildcard byte signature scan over one streamed memory region.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one region byte per item, region_end marks the region's last byte.
//   o_out : one item per region: match_found and the absolute address of the
//           first match (region base plus offset), zero when nothing matched.
//   APB   : signature, care mask, length and region base at byte addresses 8*i;
//           write only while no region is in flight.
// Throughput is one byte per cycle while the queue is not full; the masked
// window compare is evaluated in parallel on each accepted byte.
// An accepted region_end byte writes its result into the queue; the base add
// then goes into the output register once that register is free or taken.
// A two-item queue sits between the scan front and the output stage. While
// the receiver stalls, bytes keep flowing until the queue holds two results;
// i_in.ready then drops until the output register is taken.
// Reset (synchronous, active low) clears the window count, match state,
// queue and output valid; registers return to their reset values, with the
// signature length at one.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search #(
    parameter int unsigned MAX_PATTERN = 16,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mbps_byte_if.sink                        i_in,
    mbps_result_if.source                    o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    mbps_pkg::t_cfg          w_cfg;
    logic                    w_push;
    logic                    w_found;
    logic [COUNT_WIDTH-1:0]  w_offset;
    logic                    w_q_full;
    logic                    w_q_valid;
    logic [COUNT_WIDTH:0]    w_q_data;
    logic                    w_pop;

    mbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mbps_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (w_cfg),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_found  (w_found),
        .o_offset (w_offset)
    );

    mbps_queue #(
        .WIDTH (COUNT_WIDTH + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_found, w_offset}),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    mbps_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_found  (w_q_data[COUNT_WIDTH]),
        .i_q_offset (w_q_data[COUNT_WIDTH-1:0]),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule

[rtl/mbps_checker.sv]
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks for the masked byte pattern search block.
// ----------------------------------------------------------------------------
module mbps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_found,
    input logic [63:0] i_out_addr
);

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_found)
                                        && $stable(i_out_addr))
        else $error("result item changed while stalled");

    a_no_match_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_addr == 64'd0)
        else $error("address non-zero without a match");

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_found (o_out.match_found),
    .i_out_addr  (o_out.match_address)
);
